// ===== rtl/core/ptpae_pkg.sv =====
// ----------------------------------------------------------------------------
// ptpae_pkg: shared types and constants of the pointing angle encoder
// Payload structs, datapath widths, register indexes, arctangent table functions, pre-rotation.
// ----------------------------------------------------------------------------
package ptpae_pkg;

    // datapath widths
    localparam int XW         = 64;  // CORDIC x/y word
    localparam int AW         = 44;  // angle accumulator, 2^-40 rad
    localparam int ANG_W      = 17;  // rounded angle, 1/8192 rad
    localparam int ROUND_SH   = 27;  // 2^-40 rad -> 2^-13 rad
    localparam int CMD_W      = 16;
    localparam int OFS_W      = 13;
    localparam int DIST_W     = 15;
    localparam int FIN_W      = 20;  // command arithmetic before wrap

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIN_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIN_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ELEV_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ELEV_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIN_OFS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ELEV_OFS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST  = 3'd6;

    // servo command scaling: cmd = centre + trim + a * gain * 10000 / (31415 * 8192)
    localparam longint unsigned CMD_DEN   = 64'd257351680;
    localparam longint unsigned TRAIN_NUM = 64'd53330000;
    localparam longint unsigned ELEV_NUM  = 64'd80000000;
    localparam int              RECIP_SH  = 20;
    localparam logic signed [FIN_W-1:0] CENTRE = 20'sd7500;

    typedef logic signed [XW-1:0] t_word;
    typedef logic signed [AW-1:0] t_acc;
    typedef logic signed [ANG_W-1:0] t_angle;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] target_z;
    } t_target;

    typedef struct packed {
        logic [CMD_W-1:0] azimuth_command;
        logic [CMD_W-1:0] tilt_command;
    } t_command;

    typedef struct packed {
        t_word x;
        t_word y;
        t_acc  z;
    } t_vec;

    // quotient of |a| * gain * 10000 by CMD_DEN
    typedef struct packed {
        logic [CMD_W-1:0] q;
        logic             nz;   // remainder non-zero
        logic             neg;  // product negative
    } t_quot;

    // shift-subtract quotient; elaboration only
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q, r;
        int              b;
        q = 0;
        r = 0;
        for (b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/n) in 2^-40 rad, Taylor terms each truncated; elaboration only
    function automatic longint atan_recip(input longint unsigned n);
        longint unsigned one, p, nn, k;
        longint          sum, term;
        bit              done;
        int              it;
        one  = 64'd1 << 40;
        p    = n;
        nn   = n * n;
        k    = 0;
        sum  = 0;
        done = 1'b0;
        for (it = 0; it < 64; it++) begin
            if (!done) begin
                if (p > one) begin
                    done = 1'b1;
                end else begin
                    term = longint'(udiv(one, p * (2 * k + 1)));
                    sum  = k[0] ? sum - term : sum + term;
                    if (p > udiv(one, nn)) begin
                        done = 1'b1;
                    end else begin
                        p = p * nn;
                        k = k + 1;
                    end
                end
            end
        end
        return sum;
    endfunction

    // atan(2^-i); pi/4 built as atan(1/2) + atan(1/3)
    function automatic longint atan_entry(input int i);
        longint r;
        if (i == 0) begin
            r = atan_recip(64'd2) + atan_recip(64'd3);
        end else begin
            r = atan_recip(64'd1 << i);
        end
        return r;
    endfunction

    localparam t_acc HALF_PI = t_acc'(2 * atan_entry(0));

    // quarter-turn pre-rotation for points behind the y axis
    function automatic t_vec pre_rotate(input t_word x, input t_word y);
        t_vec v;
        v.x = x;
        v.y = y;
        v.z = '0;
        if (x[XW-1]) begin
            if (!y[XW-1]) begin
                v.x = y;
                v.y = -x;
                v.z = HALF_PI;
            end else begin
                v.x = -y;
                v.y = x;
                v.z = -HALF_PI;
            end
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/ptpae_stream_if.sv =====
// ----------------------------------------------------------------------------
// ptpae_stream_if: valid/ready stream channel
// One transaction moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface ptpae_stream_if #(
    parameter type t_data = ptpae_pkg::t_target
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ptpae_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// ptpae_sqrt_cell: one digit of a pipelined integer square root
// Takes two radicand bits, decides one root bit, hands on to the next cell.
// ----------------------------------------------------------------------------
module ptpae_sqrt_cell #(
    parameter int RB     = 16,
    parameter int SIDE_W = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*RB-1:0]   i_rad,
    input  logic [RB+1:0]     i_rem,
    input  logic [RB-1:0]     i_root,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [2*RB-1:0]   o_rad,
    output logic [RB+1:0]     o_rem,
    output logic [RB-1:0]     o_root,
    output logic [SIDE_W-1:0] o_side
);
    logic [RB+3:0] rem_sh, trial, diff;
    logic          take;
    logic          r_valid;
    logic [2*RB-1:0] r_rad, n_rad;
    logic [RB+1:0]   r_rem, n_rem;
    logic [RB-1:0]   r_root, n_root;
    logic [SIDE_W-1:0] r_side;

    always_comb begin
        rem_sh = {i_rem, i_rad[2*RB-1 -: 2]};
        trial  = {2'b00, i_root, 2'b01};
        take   = (rem_sh >= trial);
        diff   = rem_sh - trial;
        n_rem  = take ? diff[RB+1:0] : rem_sh[RB+1:0];
        n_root = {i_root[RB-2:0], take};
        n_rad  = {i_rad[2*RB-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;
endmodule

// ===== rtl/core/ptpae_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// ptpae_cordic_cell: one vectoring micro-rotation
// Drives y towards zero by +/- atan(2^-STAGE), floor shifts.
// ----------------------------------------------------------------------------
module ptpae_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  ptpae_pkg::t_vec  i_vec,
    output ptpae_pkg::t_vec  o_vec
);
    import ptpae_pkg::*;

    localparam t_acc ATAN = t_acc'(atan_entry(STAGE));

    t_word dx, dy;
    t_vec  r_vec, n_vec;

    always_comb begin
        dx = i_vec.y >>> STAGE;
        dy = i_vec.x >>> STAGE;
        if (!i_vec.y[XW-1]) begin
            n_vec.x = i_vec.x + dx;
            n_vec.y = i_vec.y - dy;
            n_vec.z = i_vec.z + ATAN;
        end else begin
            n_vec.x = i_vec.x - dx;
            n_vec.y = i_vec.y + dy;
            n_vec.z = i_vec.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;
endmodule

// ===== rtl/core/ptpae_cmd_unit.sv =====
// ----------------------------------------------------------------------------
// ptpae_cmd_unit: angle-to-servo scaling quotient
// floor(|a| * GAIN_NUM / CMD_DEN) by reciprocal multiply, one correction step.
// Three register stages.
// ----------------------------------------------------------------------------
module ptpae_cmd_unit #(
    parameter longint unsigned GAIN_NUM = 64'd80000000,
    parameter bit              GAIN_NEG = 1'b0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  ptpae_pkg::t_angle i_angle,
    output ptpae_pkg::t_quot  o_quot
);
    import ptpae_pkg::*;

    localparam longint unsigned RECIP = (GAIN_NUM << RECIP_SH) / CMD_DEN;
    localparam int PM_W = ANG_W + 20;
    localparam int PN_W = ANG_W + 28;

    logic [ANG_W-1:0] mag;
    logic [ANG_W-1:0] q_est;
    logic [PN_W-1:0]  rem_raw, rem_adj;
    logic             ge;

    logic [PM_W-1:0]  r_pm;
    logic [PN_W-1:0]  r_pn, r_pn2, r_pqd;
    logic [ANG_W-1:0] r_qe;
    logic             r_neg, r_neg2;
    t_quot            r_quot, n_quot;

    always_comb begin
        mag     = i_angle[ANG_W-1] ? ANG_W'(-i_angle) : ANG_W'(i_angle);
        q_est   = ANG_W'(r_pm >> RECIP_SH);
        rem_raw = r_pn2 - r_pqd;
        ge      = (rem_raw >= PN_W'(CMD_DEN));
        rem_adj = rem_raw - PN_W'(CMD_DEN);
        n_quot.q   = CMD_W'(r_qe + ANG_W'(ge));
        n_quot.nz  = ge ? (rem_adj != '0) : (rem_raw != '0);
        n_quot.neg = r_neg2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: both products
            r_pm   <= PM_W'(mag) * PM_W'(RECIP);
            r_pn   <= PN_W'(mag) * PN_W'(GAIN_NUM);
            r_neg  <= i_angle[ANG_W-1] ^ GAIN_NEG;
            // stage 2: back-multiply the estimate
            r_qe   <= q_est;
            r_pqd  <= PN_W'(q_est) * PN_W'(CMD_DEN);
            r_pn2  <= r_pn;
            r_neg2 <= r_neg;
            // stage 3: correct by at most one
            r_quot <= n_quot;
        end
    end

    assign o_quot = r_quot;
endmodule

// ===== rtl/core/pan_tilt_pointing_angle_encoder.sv =====
// ----------------------------------------------------------------------------
// pan_tilt_pointing_angle_encoder: target point to pan/tilt servo commands
// Fully pipelined; one target transaction per clock unless the output skid slot is full.
// ----------------------------------------------------------------------------
// Takes a target point (x, y, z in 1/1024 m) and returns the train and
// elevation servo command words. Inside: squares and ground-distance check,
// a chain of COORD_BITS square-root cells giving floor(sqrt(x^2 + y^2)), then
// two parallel chains of CORDIC_STAGES vectoring cells (train: atan2(y, x),
// elevation: atan2(z, distance)), angle rounding and limit check, and a
// three-stage reciprocal-multiply scaler per axis. A point that is too close
// or whose angles are not strictly inside the limits produces no result
// transaction. Throughput is one transaction per cycle while the skid slot
// is empty. Input ready drops only while the output register and its skid
// slot are both full. Configuration must be written by the user through
// i_cfg_we/i_cfg_index/i_cfg_data only while no transaction is in flight;
// the block does not enforce this. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
module pan_tilt_pointing_angle_encoder #(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ptpae_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ptpae_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ptpae_stream_if.sink                        i_target,
    ptpae_stream_if.source                      o_command
);
    import ptpae_pkg::*;

    localparam int CB        = COORD_BITS;
    localparam int CS        = CORDIC_STAGES;
    localparam int PRE_SHIFT = 60 - CB;
    localparam int SIDE_W    = 3 * CB;

    // ---------------- configuration registers ----------------
    logic signed [15:0]   r_train_min, r_train_max, r_elev_min, r_elev_max;
    logic [OFS_W-1:0]     r_train_ofs, r_elev_ofs;
    logic [DIST_W-1:0]    r_min_dist;
    logic [2*DIST_W-1:0]  r_dist_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_train_min <= -16'sd4915;
            r_train_max <= 16'sd4915;
            r_elev_min  <= -16'sd1475;
            r_elev_max  <= 16'sd1393;
            r_train_ofs <= '0;
            r_elev_ofs  <= '0;
            r_min_dist  <= 15'd102;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TRAIN_MIN: r_train_min <= i_cfg_data;
                REG_TRAIN_MAX: r_train_max <= i_cfg_data;
                REG_ELEV_MIN:  r_elev_min  <= i_cfg_data;
                REG_ELEV_MAX:  r_elev_max  <= i_cfg_data;
                REG_TRAIN_OFS: r_train_ofs <= i_cfg_data[OFS_W-1:0];
                REG_ELEV_OFS:  r_elev_ofs  <= i_cfg_data[OFS_W-1:0];
                REG_MIN_DIST:  r_min_dist  <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // threshold squared; updates in the cycle after a write, long before use
    always_ff @(posedge i_clk) begin
        r_dist_sq <= (2*DIST_W)'(r_min_dist) * (2*DIST_W)'(r_min_dist);
    end

    // ---------------- flow control ----------------
    logic en;
    logic r_skid_v, r_out_v;
    assign en             = !r_skid_v;
    assign i_target.ready = en;

    // ---------------- input stage ----------------
    logic [47:0] fx, fy, fz;
    logic                 r_in_v;
    logic signed [CB-1:0] r_x, r_y, r_z;

    // coordinates sign-extend from bit CB-1; wider fields read high bits as zero
    assign fx = {32'd0, i_target.data.target_x};
    assign fy = {32'd0, i_target.data.target_y};
    assign fz = {32'd0, i_target.data.target_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en) begin
            r_in_v <= i_target.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x <= fx[CB-1:0];
            r_y <= fy[CB-1:0];
            r_z <= fz[CB-1:0];
        end
    end

    // ---------------- squares ----------------
    logic signed [2*CB-1:0] xx_full, yy_full;
    logic                   r_sq_v;
    logic [2*CB-1:0]        r_xx, r_yy;
    logic signed [CB-1:0]   r_x1, r_y1, r_z1;

    assign xx_full = r_x * r_x;
    assign yy_full = r_y * r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
        end else if (en) begin
            r_sq_v <= r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xx <= xx_full;
            r_yy <= yy_full;
            r_x1 <= r_x;
            r_y1 <= r_y;
            r_z1 <= r_z;
        end
    end

    // ---------------- sum and distance gate ----------------
    logic [2*CB-1:0]   ssum;
    logic              far_enough;
    logic              r_s_v;
    logic [2*CB-1:0]   r_s;
    logic [SIDE_W-1:0] r_side;

    assign ssum       = r_xx + r_yy;
    assign far_enough = (64'(ssum) > 64'(r_dist_sq));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (en) begin
            r_s_v <= r_sq_v & far_enough;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s    <= ssum;
            r_side <= {r_x1, r_y1, r_z1};
        end
    end

    // ---------------- square root cell chain ----------------
    logic              sq_v    [0:CB];
    logic [2*CB-1:0]   sq_rad  [0:CB];
    logic [CB+1:0]     sq_rem  [0:CB];
    logic [CB-1:0]     sq_root [0:CB];
    logic [SIDE_W-1:0] sq_side [0:CB];

    assign sq_v[0]    = r_s_v;
    assign sq_rad[0]  = r_s;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = r_side;

    genvar gi;
    generate
        for (gi = 0; gi < CB; gi++) begin : g_sqrt
            ptpae_sqrt_cell #(
                .RB     (CB),
                .SIDE_W (SIDE_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_valid (sq_v[gi]),
                .i_rad   (sq_rad[gi]),
                .i_rem   (sq_rem[gi]),
                .i_root  (sq_root[gi]),
                .i_side  (sq_side[gi]),
                .o_valid (sq_v[gi+1]),
                .o_rad   (sq_rad[gi+1]),
                .o_rem   (sq_rem[gi+1]),
                .o_root  (sq_root[gi+1]),
                .o_side  (sq_side[gi+1])
            );
        end
    endgenerate

    // ---------------- scale and pre-rotate ----------------
    logic signed [CB-1:0] px, py, pz;
    t_word                sx, sy, sz, sh;
    logic                 r_prep_v;
    t_vec                 r_prep_tr, r_prep_el;

    always_comb begin
        px = sq_side[CB][3*CB-1:2*CB];
        py = sq_side[CB][2*CB-1:CB];
        pz = sq_side[CB][CB-1:0];
        sx = t_word'(px) <<< PRE_SHIFT;
        sy = t_word'(py) <<< PRE_SHIFT;
        sz = t_word'(pz) <<< PRE_SHIFT;
        sh = t_word'({1'b0, sq_root[CB]}) <<< PRE_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_v <= 1'b0;
        end else if (en) begin
            r_prep_v <= sq_v[CB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prep_tr <= pre_rotate(sx, sy);
            r_prep_el <= pre_rotate(sh, sz);   // leg is never negative
        end
    end

    // ---------------- CORDIC cell chains ----------------
    t_vec          tr [0:CS];
    t_vec          el [0:CS];
    logic [CS:1]   r_cv;

    assign tr[0] = r_prep_tr;
    assign el[0] = r_prep_el;

    generate
        for (gi = 0; gi < CS; gi++) begin : g_cordic
            ptpae_cordic_cell #(.STAGE(gi)) u_train (
                .i_clk (i_clk),
                .i_en  (en),
                .i_vec (tr[gi]),
                .o_vec (tr[gi+1])
            );
            ptpae_cordic_cell #(.STAGE(gi)) u_elev (
                .i_clk (i_clk),
                .i_en  (en),
                .i_vec (el[gi]),
                .o_vec (el[gi+1])
            );
        end
    endgenerate

    // valid bits ride alongside the CORDIC cells (CS must be kept at least 8; the block does not check it)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
        end else if (en) begin
            r_cv <= {r_cv[CS-1:1], r_prep_v};
        end
    end

    // ---------------- round and limit check ----------------
    t_acc   ztr, zel;
    t_angle ta, ea;
    logic   in_limits;
    logic   r_ang_v;
    t_angle r_ta, r_ea;

    always_comb begin
        ztr = (tr[CS].z + (t_acc'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
        zel = (el[CS].z + (t_acc'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
        ta  = ztr[ANG_W-1:0];
        ea  = zel[ANG_W-1:0];
        in_limits = (t_angle'(r_train_min) < ta) && (ta < t_angle'(r_train_max)) &&
                    (t_angle'(r_elev_min) < ea) && (ea < t_angle'(r_elev_max));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_v <= 1'b0;
        end else if (en) begin
            r_ang_v <= r_cv[CS] & in_limits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ta <= ta;
            r_ea <= ea;
        end
    end

    // ---------------- command scaling ----------------
    t_quot      quot_tr, quot_el;
    logic [2:0] r_cmd_v;

    ptpae_cmd_unit #(
        .GAIN_NUM (TRAIN_NUM),
        .GAIN_NEG (1'b1)
    ) u_cmd_train (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_ta),
        .o_quot  (quot_tr)
    );

    ptpae_cmd_unit #(
        .GAIN_NUM (ELEV_NUM),
        .GAIN_NEG (1'b0)
    ) u_cmd_elev (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_ea),
        .o_quot  (quot_el)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_v <= '0;
        end else if (en) begin
            r_cmd_v <= {r_cmd_v[1:0], r_ang_v};
        end
    end

    // centre + trim + signed quotient, truncated toward zero
    logic signed [FIN_W-1:0] c_tr, c_el, t_tr, t_el, fl_tr, fl_el, res_tr, res_el;
    t_command fin;

    always_comb begin
        c_tr  = CENTRE + FIN_W'($signed(r_train_ofs));
        c_el  = CENTRE + FIN_W'($signed(r_elev_ofs));
        t_tr  = quot_tr.neg ? -(FIN_W'(quot_tr.q) + FIN_W'(quot_tr.nz)) : FIN_W'(quot_tr.q);
        t_el  = quot_el.neg ? -(FIN_W'(quot_el.q) + FIN_W'(quot_el.nz)) : FIN_W'(quot_el.q);
        fl_tr = c_tr + t_tr;
        fl_el = c_el + t_el;
        res_tr = fl_tr + FIN_W'(fl_tr[FIN_W-1] & quot_tr.nz);
        res_el = fl_el + FIN_W'(fl_el[FIN_W-1] & quot_el.nz);
        fin.azimuth_command = res_tr[CMD_W-1:0];
        fin.tilt_command    = res_el[CMD_W-1:0];
    end

    // ---------------- output register and skid slot ----------------
    t_command r_out, r_skid;
    logic     fin_v;
    assign fin_v = r_cmd_v[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_command.ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (fin_v) begin
            if (!r_out_v || o_command.ready) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (o_command.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (o_command.ready) begin
                r_out <= r_skid;
            end
        end else if (fin_v) begin
            if (!r_out_v || o_command.ready) begin
                r_out <= fin;
            end else begin
                r_skid <= fin;
            end
        end
    end

    assign o_command.valid = r_out_v;
    assign o_command.data  = r_out;
endmodule

// ===== test/tb_pan_tilt_pointing_angle_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_pan_tilt_pointing_angle_encoder: self-checking bench for the encoder
// Drives target points, predicts the servo command words with an independent
// CORDIC model and checks every command transaction in order.
// ----------------------------------------------------------------------------
module tb_pan_tilt_pointing_angle_encoder;
    import ptpae_pkg::*;

    localparam int     STAGES    = 16;
    localparam int     PRE_SH    = 44;            // 60 - coordinate width
    localparam longint SCALE_DEN = 64'd257351680; // 31415 * 8192
    localparam int     DRAIN_CYC = 60;            // above the pipeline latency
    localparam int     WD_LIMIT  = 5000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ptpae_stream_if #(.t_data(t_target))  tgt ();
    ptpae_stream_if #(.t_data(t_command)) cmd ();

    pan_tilt_pointing_angle_encoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_target    (tgt),
        .o_command   (cmd)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // shadow copy of the register file
    logic signed [15:0] train_lo, train_hi, elev_lo, elev_hi;
    logic signed [12:0] az_trim, elev_trim;
    logic        [14:0] ground_min;

    longint   arctan_tab [STAGES];
    t_command pending_cmds [$];

    int  idle_pct, stall_pct;
    int  errors, checked, sent_pts, watchdog;

    // atan(1/n) in 2^-40 rad, each series term truncated
    function automatic longint arctan_inv(input longint unsigned n);
        longint unsigned one, p, nn, k;
        longint          acc, term;
        one = 64'd1 << 40;
        p   = n;
        nn  = n * n;
        k   = 0;
        acc = 0;
        while (p <= one) begin
            term = longint'(one / (p * (2 * k + 1)));
            acc  = k[0] ? acc - term : acc + term;
            if (p > one / nn) break;
            p = p * nn;
            k++;
        end
        return acc;
    endfunction

    // vectoring: angle of (x, y), rounded to 1/8192 rad
    function automatic longint bearing(input longint x0, input longint y0);
        longint x, y, z, t, dx, dy;
        x = x0 <<< PRE_SH;
        y = y0 <<< PRE_SH;
        z = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 2 * arctan_tab[0];
            end else begin
                t = x; x = -y; y = t; z = -2 * arctan_tab[0];
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += arctan_tab[i];
            end else begin
                x -= dx; y += dy; z -= arctan_tab[i];
            end
        end
        return (z + (64'sd1 <<< 26)) >>> 27;
    endfunction

    function automatic longint floor_sqrt(input longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic logic [15:0] servo_word(input longint a, input longint trim,
                                               input longint gain);
        longint q;
        q = ((64'sd7500 + trim) * SCALE_DEN + a * gain * 10000) / SCALE_DEN;
        return q[15:0];
    endfunction

    function automatic void angles_of(input t_target p, output longint ta,
                                      output longint ea, output longint sq);
        longint x, y;
        x  = p.target_x;
        y  = p.target_y;
        sq = x * x + y * y;
        ta = bearing(x, y);
        ea = bearing(floor_sqrt(sq), longint'(p.target_z));
    endfunction

    // expected command for one point; 0 when the point is rejected
    function automatic bit point_commands(input t_target p, output t_command c);
        longint ta, ea, sq, d;
        angles_of(p, ta, ea, sq);
        d = ground_min;
        c = '0;
        if (sq <= d * d) return 1'b0;
        if (!(train_lo < ta && ta < train_hi && elev_lo < ea && ea < elev_hi))
            return 1'b0;
        c.azimuth_command = servo_word(ta, az_trim, -5333);
        c.tilt_command    = servo_word(ea, elev_trim, 8000);
        return 1'b1;
    endfunction

    // ---- register writes (call right after posedge i_clk) -------------------
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[15:0];
        case (idx)
            REG_TRAIN_MIN: train_lo   = val[15:0];
            REG_TRAIN_MAX: train_hi   = val[15:0];
            REG_ELEV_MIN:  elev_lo    = val[15:0];
            REG_ELEV_MAX:  elev_hi    = val[15:0];
            REG_TRAIN_OFS: az_trim    = val[12:0];
            REG_ELEV_OFS:  elev_trim  = val[12:0];
            REG_MIN_DIST:  ground_min = val[14:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        tgt.valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic set_limits(input int tmin, input int tmax, input int emin,
                              input int emax, input int tofs, input int eofs,
                              input int dmin);
        wait_drained();
        reg_write(REG_TRAIN_MIN, tmin);
        reg_write(REG_TRAIN_MAX, tmax);
        reg_write(REG_ELEV_MIN, emin);
        reg_write(REG_ELEV_MAX, emax);
        reg_write(REG_TRAIN_OFS, tofs);
        reg_write(REG_ELEV_OFS, eofs);
        reg_write(REG_MIN_DIST, dmin);
        i_cfg_we <= 1'b0;
    endtask

    // ---- one target transaction ---------------------------------------------
    task automatic send_point(input t_target p);
        t_command c;
        bit       rdy;
        while ($urandom_range(0, 99) < idle_pct) begin
            tgt.valid <= 1'b0;
            @(posedge i_clk);
        end
        tgt.valid <= 1'b1;
        tgt.data  <= p;
        do begin
            @(negedge i_clk);
            rdy = tgt.ready;
            @(posedge i_clk);
        end while (!rdy);
        sent_pts++;
        if (point_commands(p, c)) pending_cmds.push_back(c);
    endtask

    task automatic send_xyz(input int x, input int y, input int z);
        t_target p;
        p.target_x = x[15:0];
        p.target_y = y[15:0];
        p.target_z = z[15:0];
        send_point(p);
    endtask

    // mostly points within plausible angles, in front of the mount unless behind_ok lets them flip behind
    function automatic t_target random_point(input bit behind_ok);
        t_target p;
        int x, y, z;
        if ($urandom_range(0, 99) < 75) begin
            x = $urandom_range(200, 32767);
            y = int'($urandom_range(0, 2 * x)) - x;
            z = int'($urandom_range(0, x / 3)) - x / 6;
            if (behind_ok && $urandom_range(0, 1)) x = -x;
            p.target_x = x[15:0];
            p.target_y = y[15:0];
            p.target_z = z[15:0];
        end else begin
            p = t_target'(48'({$urandom, $urandom}));
        end
        return p;
    endfunction

    // ---- checker and watchdog -------------------------------------------
    always @(posedge i_clk) begin
        t_command want;
        cmd.ready <= ($urandom_range(0, 99) >= stall_pct);
        if (i_rst_n && cmd.valid && cmd.ready) begin
            if (pending_cmds.size() == 0) begin
                errors++;
                $display("%0t: unexpected command transaction %h", $time, cmd.data);
            end else begin
                want = pending_cmds.pop_front();
                checked++;
                if (cmd.data.azimuth_command !== want.azimuth_command) begin
                    errors++;
                    $display("%0t: azimuth_command expected %h actual %h", $time,
                             want.azimuth_command, cmd.data.azimuth_command);
                end
                if (cmd.data.tilt_command !== want.tilt_command) begin
                    errors++;
                    $display("%0t: tilt_command expected %h actual %h", $time,
                             want.tilt_command, cmd.data.tilt_command);
                end
            end
        end
        if ((tgt.valid && tgt.ready) || (cmd.valid && cmd.ready)) begin
            watchdog <= 0;
        end else if (watchdog >= WD_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WD_LIMIT);
            $display("tb_pan_tilt_pointing_angle_encoder: FAIL");
            $finish;
        end else begin
            watchdog <= watchdog + 1;
        end
    end

    // ---- tests --------------------------------------------------------------
    task automatic test_field_extremes();
        int v [5] = '{-32768, -1, 0, 1, 32767};
        set_limits(-25736, 25736, -25736, 25736, -4096, 4095, 0);
        foreach (v[i]) send_xyz(v[i], v[(i + 2) % 5], v[4 - i]);
        send_xyz(0, 0, 0);                 // origin: rejected even at zero distance
        send_xyz(-32768, 0, 5);            // directly behind
        send_xyz(-300, -1, -7);            // behind, just below the axis
        set_limits(-25736, 25736, -25736, 25736, 4095, -4096, 32767);
        send_xyz(-32768, -32768, 32767);   // far corner clears the largest distance
        send_xyz(32767, 0, 0);
    endtask

    task automatic test_short_distance();
        set_limits(-25736, 25736, -25736, 25736, 0, 0, 102);
        send_xyz(102, 0, 0);               // exactly on the distance: rejected
        send_xyz(103, 0, 0);
        send_xyz(72, 72, 1);
        send_xyz(0, -103, 0);
    endtask

    task automatic test_angle_on_limit();
        t_target p;
        longint  ta, ea, sq;
        p = '{target_x: 16'sd9000, target_y: 16'sd2345, target_z: 16'sd700};
        angles_of(p, ta, ea, sq);
        set_limits(-25736, int'(ta), -25736, 25736, 0, 0, 0);
        send_point(p);                     // train angle on the upper limit
        set_limits(int'(ta), 25736, -25736, 25736, 0, 0, 0);
        send_point(p);                     // on the lower limit
        set_limits(-25736, 25736, int'(ea), int'(ea) + 1, 0, 0, 0);
        send_point(p);                     // elevation on its lower limit
        set_limits(int'(ta) - 1, int'(ta) + 1, int'(ea) - 1, int'(ea) + 1, 0, 0, 0);
        send_point(p);                     // strictly inside both: accepted
    endtask

    task automatic test_crossed_limits();
        set_limits(100, -100, -25736, 25736, 0, 0, 0);
        repeat (3) send_point(random_point(1'b1));
        set_limits(-25736, 25736, 500, 500, 0, 0, 0);
        repeat (3) send_point(random_point(1'b1));
        wait_drained();
        reg_write(3'd7, 16'h1234);         // unused index: no register changes
        i_cfg_we <= 1'b0;
        send_xyz(5000, 100, 3000);
    endtask

    task automatic run_random(input int n, input int idle, input int stall,
                              input bit behind_ok);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n) send_point(random_point(behind_ok));
    endtask

    task automatic test_random_traffic();
        set_limits(-4915, 4915, -1475, 1393, 0, 0, 102);
        run_random(270, 0, 0, 1'b0);
        set_limits(-25736, 25736, -25736, 25736, -4096, 4095, 0);
        run_random(270, 51, 0, 1'b1);
        wait_drained();                    // sender holds off until all results are in
        set_limits(-12000, 9000, -3000, 6000, 4095, -4096, 20000);
        run_random(270, 0, 51, 1'b1);
        set_limits(-2000, 15000, -800, 2500, 1234, -777, 3000);
        run_random(270, 23, 23, 1'b1);
        set_limits(-25736, 25736, -25736, 25736, -1, 1, 1);
        run_random(270, 0, 0, 1'b1);
    endtask

    initial begin
        int spins;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        tgt.valid   = 1'b0;
        tgt.data    = '0;
        cmd.ready   = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        errors      = 0;
        checked     = 0;
        sent_pts    = 0;
        watchdog    = 0;
        train_lo    = -16'sd4915;
        train_hi    = 16'sd4915;
        elev_lo     = -16'sd1475;
        elev_hi     = 16'sd1393;
        az_trim     = '0;
        elev_trim   = '0;
        ground_min  = 15'd102;
        arctan_tab[0] = arctan_inv(2) + arctan_inv(3);
        for (int i = 1; i < STAGES; i++) arctan_tab[i] = arctan_inv(64'd1 << i);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values first, before any register write
        send_xyz(10000, 500, 200);
        send_xyz(10000, 9000, 200);
        test_field_extremes();
        test_short_distance();
        test_angle_on_limit();
        test_crossed_limits();
        test_random_traffic();

        tgt.valid <= 1'b0;
        spins = 0;
        while (pending_cmds.size() != 0 && spins < 100000) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Covered %0d target points, %0d command words checked,", sent_pts, checked);
        $display("over five limit/trim settings with sender gaps and receiver stalls.");
        if (errors == 0 && pending_cmds.size() == 0) begin
            $display("tb_pan_tilt_pointing_angle_encoder: PASS");
        end else begin
            $display("%0d mismatches, %0d results never seen", errors, pending_cmds.size());
            $display("tb_pan_tilt_pointing_angle_encoder: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ptpae_pkg.sv
rtl/core/ptpae_stream_if.sv
rtl/core/ptpae_sqrt_cell.sv
rtl/core/ptpae_cordic_cell.sv
rtl/core/ptpae_cmd_unit.sv
rtl/core/pan_tilt_pointing_angle_encoder.sv
test/tb_pan_tilt_pointing_angle_encoder.sv
